// ===== hdl/lssd_pkg.sv =====
package lssd_pkg;

   localparam int VALUE_W         = 16;
   localparam int POS_W           = 16;
   localparam int LEN_W           = 17;
   localparam int DIV_W           = 9;
   localparam int MAX_DIVISOR_DEF = 256;
   localparam int MAX_LENGTH      = 65536;
   // prefix sum is one bit wider than an element, magnitude fits the element width
   localparam int SUM_W           = VALUE_W + 1;
   localparam int MAG_W           = VALUE_W;
   localparam int DIV_STEPS       = MAG_W;
   localparam int CNT_W           = $clog2(DIV_STEPS);
   localparam logic [DIV_W-1:0] DIVISOR_RESET = DIV_W'(1);

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      last;
   } lssd_req_type;

   typedef struct packed {
      logic [LEN_W-1:0] best_length;
      logic             final_res;
   } lssd_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_RES,
      ST_READ,
      ST_UPD
   } lssd_state_type;

endpackage

// ===== hdl/longest_subarray_sum_divisible.sv =====
// Streams signed elements and answers each one with the length of the longest
// contiguous run, so far in the current sequence, whose sum is a multiple of
// the divisor in csr_wr_data (0 acts as 1, values above MAX_DIVISOR act as
// MAX_DIVISOR). The prefix sum is formed in the transfer cycle itself; it then
// passes through the shared restoring divider (one quotient bit per cycle over
// the 16-bit magnitude), a step that folds the remainder into a floor residue,
// the first-index table read and the update of the best length, which loads
// the result into the output register. The next item is taken in the cycle
// after that update, so no new item enters while one is in flight; a result
// held by rsp_stall keeps the item behind it in the update step and holds off
// new items. Sequence position saturates at 65535. The item flagged last ends
// the sequence and clears residue, position, best length and all table valid
// bits.
module longest_subarray_sum_divisible
   import lssd_pkg::*;
#(
   parameter int MAX_DIVISOR = MAX_DIVISOR_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  lssd_req_type       req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output lssd_rsp_type       rsp_data,
   input  logic               csr_wr_en,
   input  logic [DIV_W-1:0]   csr_wr_data
);

   localparam int KW    = $clog2(MAX_DIVISOR + 1);
   localparam int RES_W = $clog2(MAX_DIVISOR);

   lssd_state_type state_ff, state_in;

   logic [DIV_W-1:0]       divisor_ff;
   logic [RES_W-1:0]       prefix_ff, prefix_in;
   logic [POS_W-1:0]       position_ff, position_in;
   logic [LEN_W-1:0]       longest_ff, longest_in;
   logic [MAX_DIVISOR-1:0] seen_ff, seen_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic [MAG_W-1:0]       mag_ff, mag_in;
   logic [KW-1:0]          rem_ff, rem_in;
   logic [KW-1:0]          k_ff, k_in;
   logic                   neg_ff, neg_in;
   logic                   last_ff, last_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [RES_W-1:0]       res_ff, res_in;
   logic [POS_W-1:0]       rd_data_ff;
   lssd_rsp_type           rsp_data_ff, rsp_data_in;

   logic [POS_W-1:0]       first_index_mem [MAX_DIVISOR];

   logic                   req_fire;
   logic                   out_free;
   logic                   upd_fire;
   logic                   mem_we;
   logic signed [SUM_W-1:0] sum;
   logic [KW:0]            shifted;
   logic [KW:0]            diff;
   logic [KW-1:0]          k_eff;
   logic [LEN_W-1:0]       cand;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign upd_fire  = (state_ff == ST_UPD) && out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      if (divisor_ff == '0) begin
         k_eff = KW'(1);
      end else if (32'(divisor_ff) > 32'(MAX_DIVISOR)) begin
         k_eff = KW'(MAX_DIVISOR);
      end else begin
         k_eff = KW'(divisor_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      prefix_in    = prefix_ff;
      position_in  = position_ff;
      longest_in   = longest_ff;
      seen_in      = seen_ff;
      mag_in       = mag_ff;
      rem_in       = rem_ff;
      k_in         = k_ff;
      neg_in       = neg_ff;
      last_in      = last_ff;
      cnt_in       = cnt_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mem_we       = 1'b0;
      sum          = {req_data.value[VALUE_W-1], req_data.value}
                     + SUM_W'(prefix_ff);
      shifted      = {rem_ff, mag_ff[MAG_W-1]};
      diff         = shifted - {1'b0, k_ff};
      cand         = LEN_W'(position_ff - rd_data_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               neg_in  = sum[SUM_W-1];
               mag_in  = sum[SUM_W-1] ? MAG_W'(-sum) : MAG_W'(sum);
               rem_in  = '0;
               k_in    = k_eff;
               last_in = req_data.last;
               cnt_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // restoring step, one magnitude bit per cycle
            rem_in = (shifted >= {1'b0, k_ff}) ? diff[KW-1:0] : shifted[KW-1:0];
            mag_in = {mag_ff[MAG_W-2:0], 1'b0};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_RES;
            end
         end
         ST_RES: begin
            // floor residue: a negative sum with a nonzero remainder folds to k - rem
            res_in = (neg_ff && rem_ff != '0) ? RES_W'(k_ff - rem_ff) : RES_W'(rem_ff);
            state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_UPD;
         end
         ST_UPD: begin
            if (out_free) begin
               prefix_in = res_ff;
               if (res_ff == '0) begin
                  longest_in = LEN_W'(position_ff) + LEN_W'(1);
               end else if (!seen_ff[res_ff]) begin
                  seen_in[res_ff] = 1'b1;
                  mem_we = 1'b1;
               end else if (rd_data_ff <= position_ff && cand > longest_ff) begin
                  longest_in = cand;
               end
               rsp_data_in.best_length = longest_in;
               rsp_data_in.final_res   = last_ff;
               rsp_valid_in = 1'b1;
               if (position_ff != POS_W'(MAX_LENGTH - 1)) begin
                  position_in = position_ff + POS_W'(1);
               end
               if (last_ff) begin
                  prefix_in   = '0;
                  position_in = '0;
                  longest_in  = '0;
                  seen_in     = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         divisor_ff   <= DIVISOR_RESET;
         prefix_ff    <= '0;
         position_ff  <= '0;
         longest_ff   <= '0;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            divisor_ff <= csr_wr_data;
         end
         prefix_ff    <= prefix_in;
         position_ff  <= position_in;
         longest_ff   <= longest_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      rem_ff      <= rem_in;
      k_ff        <= k_in;
      neg_ff      <= neg_in;
      last_ff     <= last_in;
      cnt_ff      <= cnt_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         first_index_mem[res_ff] <= position_ff;
      end
      if (state_ff == ST_READ) begin
         rd_data_ff <= first_index_mem[res_ff];
      end
   end

`ifndef SYNTHESIS
   a_accept_starts_divide: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_DIV)
      else $error("transfer did not start the divider");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> rem_ff < k_ff)
      else $error("partial remainder not below divisor");

   a_residue_below_divisor: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> KW'(res_ff) < k_ff)
      else $error("residue out of range");

   a_longest_bounded: assert property (@(posedge clock) disable iff (reset)
      longest_ff <= LEN_W'(position_ff) + LEN_W'(1))
      else $error("best length exceeds position");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      upd_fire && last_ff |=> position_ff == '0 && seen_ff == '0 && longest_ff == '0)
      else $error("sequence state not cleared after last");
`endif

endmodule

// ===== test/tb_longest_subarray_sum_divisible.sv =====
`timescale 1ns / 1ps

module tb_longest_subarray_sum_divisible;
   import lssd_pkg::*;

   localparam int RANDOM_ITEMS = 1290;

   typedef struct {
      bit                        wr;
      logic [DIV_W-1:0]          divisor;
      logic signed [VALUE_W-1:0] value;
      logic                      last;
      bit                        pinned;
      logic [LEN_W-1:0]          len;
   } stim_row_type;

   // divisor writes come first in a row; pinned rows carry a hand-worked length
   stim_row_type directed_rows [22] = '{
      '{0,   0,      5, 0, 1, 1},
      '{0,   0, -32768, 1, 1, 2},
      '{1,   0,  32767, 1, 1, 1},
      '{1, 256, -32768, 0, 1, 1},
      '{0,   0,  32767, 0, 1, 1},
      '{0,   0,      1, 0, 1, 3},
      '{0,   0,     -1, 1, 1, 3},
      '{1, 511,    255, 0, 1, 0},
      '{0,   0,      0, 0, 1, 1},
      '{0,   0,   -255, 1, 1, 3},
      '{1,   7,      3, 0, 0, 0},
      '{0,   0,      4, 0, 0, 0},
      '{0,   0,    -10, 0, 0, 0},
      '{1,   5,      2, 0, 0, 0},
      '{0,   0,     -7, 1, 0, 0},
      '{1, 257,      1, 0, 0, 0},
      '{0,   0,     -2, 1, 0, 0},
      '{1,   3,     -1, 0, 0, 0},
      '{0,   0, -32768, 0, 0, 0},
      '{0,   0,  32767, 1, 0, 0},
      '{1,   2,      1, 0, 0, 0},
      '{0,   0,      1, 1, 0, 0}
   };

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   lssd_req_type       req_data = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   lssd_rsp_type       rsp_data;
   logic               csr_wr_en = 1'b0;
   logic [DIV_W-1:0]   csr_wr_data = '0;

   // hand-worked expectation that travels with the item on the request side
   logic               pin_valid = 1'b0;
   lssd_rsp_type       pin_rsp = '0;

   int                 burst_left = 0;
   int                 issued = 0;
   int                 returned = 0;
   int                 fail_count = 0;
   int                 stall_seg_left = 0;

   // predictor state
   logic [DIV_W-1:0]   run_divisor;
   logic [7:0]         run_residue;
   logic [POS_W-1:0]   run_position;
   logic [LEN_W-1:0]   run_longest;
   logic [POS_W-1:0]   first_position [MAX_DIVISOR_DEF];
   bit                 residue_seen [MAX_DIVISOR_DEF];
   lssd_rsp_type       expected_lengths [$];

   longest_subarray_sum_divisible dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void end_sequence();
      run_residue = '0;
      run_position = '0;
      run_longest = '0;
      residue_seen = '{default: 1'b0};
   endfunction

   function automatic lssd_rsp_type step_divisible_run(input lssd_req_type item);
      int k;
      int folded;
      logic [POS_W-1:0] span;
      lssd_rsp_type result;
      if (run_divisor == '0) begin
         k = 1;
      end else if (run_divisor > MAX_DIVISOR_DEF) begin
         k = MAX_DIVISOR_DEF;
      end else begin
         k = int'(run_divisor);
      end
      // floor residue of the running prefix sum
      folded = (int'(run_residue) + int'(item.value)) % k;
      if (folded < 0) folded += k;
      run_residue = folded[7:0];
      if (folded == 0) begin
         run_longest = LEN_W'(run_position) + LEN_W'(1);
      end else if (!residue_seen[folded]) begin
         residue_seen[folded] = 1'b1;
         first_position[folded] = run_position;
      end else begin
         span = run_position - first_position[folded];
         if (first_position[folded] <= run_position && LEN_W'(span) > run_longest)
            run_longest = LEN_W'(span);
      end
      result.best_length = run_longest;
      result.final_res = item.last;
      if (run_position != POS_W'(MAX_LENGTH - 1)) run_position++;
      if (item.last) end_sequence();
      return result;
   endfunction

   task automatic report_miss(input string what, input int want, input int got);
      fail_count++;
      if (fail_count <= 10)
         $display("mismatch on result %0d: %s expected %0d, got %0d", returned, what, want, got);
   endtask

   always @(posedge clock) begin : scoreboard
      lssd_rsp_type want;
      if (reset) begin
         run_divisor = DIVISOR_RESET;
         end_sequence();
         expected_lengths.delete();
      end else begin
         if (csr_wr_en) run_divisor = csr_wr_data;
         // results first, so a stray result never pairs with an item of this edge
         if (rsp_valid && !rsp_stall) begin
            returned++;
            if (expected_lengths.size() == 0) begin
               report_miss("unexpected result, best_length", -1, int'(rsp_data.best_length));
            end else begin
               want = expected_lengths.pop_front();
               if (rsp_data.best_length !== want.best_length)
                  report_miss("best_length", int'(want.best_length),
                              int'(rsp_data.best_length));
               if (rsp_data.final_res !== want.final_res)
                  report_miss("final_res", int'(want.final_res), int'(rsp_data.final_res));
            end
         end
         if (req_valid && !req_stall) begin
            want = step_divisible_run(req_data);
            if (pin_valid) want = pin_rsp;
            expected_lengths.push_back(want);
         end
      end
   end

   // receiver: open and stalled segments of random length; a stalled one is always followed by an open one
   always @(posedge clock) begin
      if (stall_seg_left == 0) begin
         if (rsp_stall || $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b0;
            stall_seg_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 200)
                                                        : $urandom_range(1, 12);
         end else begin
            rsp_stall <= 1'b1;
            stall_seg_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                        : $urandom_range(1, 6);
         end
      end
      stall_seg_left--;
   end

   task automatic send_item(input lssd_req_type item, input bit pinned,
                            input lssd_rsp_type pinned_rsp);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80)
                                                 : $urandom_range(1, 8);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data <= item;
      pin_valid <= pinned;
      pin_rsp <= pinned_rsp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      issued++;
   endtask

   // divisor writes only once every result has come back
   task automatic set_divisor(input logic [DIV_W-1:0] divisor);
      req_valid <= 1'b0;
      while (returned != issued) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= divisor;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      lssd_req_type item;
      logic [DIV_W-1:0] divisor;
      int eff_k;
      int phase_len;
      int seq_left;
      int pick;
      int sent;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].wr) set_divisor(directed_rows[i].divisor);
         item.value = directed_rows[i].value;
         item.last = directed_rows[i].last;
         send_item(item, directed_rows[i].pinned, '{directed_rows[i].len, item.last});
      end

      sent = 0;
      seq_left = 0;
      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0: divisor = '0;
            1: divisor = DIV_W'($urandom_range(MAX_DIVISOR_DEF + 1, (1 << DIV_W) - 1));
            2: divisor = DIV_W'(MAX_DIVISOR_DEF);
            3: divisor = DIV_W'(1);
            4, 5, 6: divisor = DIV_W'($urandom_range(2, 16));
            default: divisor = DIV_W'($urandom_range(2, MAX_DIVISOR_DEF - 1));
         endcase
         if (divisor == '0) eff_k = 1;
         else if (divisor > MAX_DIVISOR_DEF) eff_k = MAX_DIVISOR_DEF;
         else eff_k = int'(divisor);
         // a sequence may run on across the write, picking up the new divisor
         set_divisor(divisor);
         phase_len = $urandom_range(10, 90);
         repeat (phase_len) begin
            if (seq_left == 0)
               seq_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 300)
                                                     : $urandom_range(1, 24);
            case ($urandom_range(0, 7))
               0: pick = int'($urandom_range(0, 65535));
               1: begin
                  case ($urandom_range(0, 3))
                     0: pick = -32768;
                     1: pick = 32767;
                     2: pick = 0;
                     default: pick = -1;
                  endcase
               end
               2: begin
                  pick = eff_k * int'($urandom_range(0, 32767 / eff_k));
                  if ($urandom_range(0, 1) == 1) pick = -pick;
               end
               default: pick = int'($urandom_range(0, 2 * eff_k)) - eff_k;
            endcase
            item.value = pick[VALUE_W-1:0];
            item.last = (seq_left == 1);
            seq_left--;
            send_item(item, 1'b0, '0);
            sent++;
         end
      end

      req_valid <= 1'b0;
      while (returned != issued) @(posedge clock);
      repeat (40) @(posedge clock);
      if (expected_lengths.size() != 0)
         $display("%0d expected results never arrived", expected_lengths.size());
      if (fail_count == 0 && expected_lengths.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #30_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/lssd_pkg.sv
hdl/longest_subarray_sum_divisible.sv
test/tb_longest_subarray_sum_divisible.sv
